/* hdl/obb_overlap_test_top_macros.svh */
// assertion helpers for the box overlap test
`ifndef OBB_OVERLAP_TEST_TOP_MACROS_SVH
`define OBB_OVERLAP_TEST_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define OBB_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication, off during reset
`define OBB_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

/* hdl/obb_pkg.sv */
package obb_pkg;

  typedef logic signed [15:0] s16_t;
  typedef logic        [15:0] u16_t;
  typedef logic signed [16:0] s17_t;
  typedef logic signed [19:0] s20_t;
  typedef logic signed [31:0] s32_t;
  typedef logic signed [32:0] s33_t;
  typedef logic signed [33:0] s34_t;
  typedef logic signed [34:0] s35_t;
  typedef logic signed [36:0] s37_t;
  typedef logic signed [39:0] s40_t;
  typedef logic signed [54:0] s55_t;
  typedef logic signed [57:0] s58_t;

  localparam int unsigned Frac = 14;
  localparam logic [7:0] EpsReset = 8'd2;
  localparam logic [3:0] NoAxis = 4'd15;
  localparam int unsigned NumAxes = 15;

  // cyclic successor tables for the cross-product axes
  localparam int unsigned Nx1[3] = '{1, 2, 0};
  localparam int unsigned Nx2[3] = '{2, 0, 1};

  // unpacked box pair as it enters the pipeline
  typedef struct {
    s16_t a[3][3];
    s16_t b[3][3];
    s16_t ca[3];
    s16_t cb[3];
    u16_t ea[3];
    u16_t eb[3];
  } box_pair_t;

  // rotation terms and offset products
  typedef struct {
    s20_t r[3][3];
    s20_t ar[3][3];
    s33_t tp[3][3];
    u16_t ea[3];
    u16_t eb[3];
  } rot_t;

  // projected radii, offset products and face-A verdicts
  typedef struct {
    s40_t rad_b[3];
    s40_t rad_e[3][3];
    s55_t tr[3][3][3];
    logic [2:0] sep_a;
  } proj_t;

endpackage

/* hdl/obb_overlap_test_top.sv */
// oriented box overlap test, 15 separating axes
// pipeline: obb_rot, obb_proj, then obb_sep, from input item accept to result valid
// throughput: one item per cycle while no back pressure stalls, set by the fully pipelined multiplier array
// back pressure stalls only the stages that hold an item
// reset: all stage valids clear, epsilon returns to 2
module obb_overlap_test_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] axis_a_x_i,
  input  logic [47:0] axis_a_y_i,
  input  logic [47:0] axis_a_z_i,
  input  logic [47:0] axis_b_x_i,
  input  logic [47:0] axis_b_y_i,
  input  logic [47:0] axis_b_z_i,
  input  logic [47:0] center_a_i,
  input  logic [47:0] center_b_i,
  input  logic [47:0] half_extents_a_i,
  input  logic [47:0] half_extents_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        overlap_o,
  output logic [3:0]  separating_axis_o
);
  import obb_pkg::*;

  logic [7:0] eps_q;
  box_pair_t box;
  rot_t rot;
  proj_t proj;
  logic rot_valid, rot_ready, proj_valid, proj_ready;

  // epsilon register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // unpack the three components of each field
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      box.a[0][k] = axis_a_x_i[16*k +: 16];
      box.a[1][k] = axis_a_y_i[16*k +: 16];
      box.a[2][k] = axis_a_z_i[16*k +: 16];
      box.b[0][k] = axis_b_x_i[16*k +: 16];
      box.b[1][k] = axis_b_y_i[16*k +: 16];
      box.b[2][k] = axis_b_z_i[16*k +: 16];
      box.ca[k]   = center_a_i[16*k +: 16];
      box.cb[k]   = center_b_i[16*k +: 16];
      box.ea[k]   = half_extents_a_i[16*k +: 16];
      box.eb[k]   = half_extents_b_i[16*k +: 16];
    end
  end

  obb_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .box_i   (box),
    .eps_i   (eps_q),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .rot_o   (rot)
  );

  obb_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .rot_i   (rot),
    .valid_o (proj_valid),
    .ready_i (proj_ready),
    .proj_o  (proj)
  );

  obb_sep u_sep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (proj_valid),
    .ready_o   (proj_ready),
    .proj_i    (proj),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .overlap_o (overlap_o),
    .axis_o    (separating_axis_o)
  );

endmodule

/* hdl/obb_rot.sv */
module obb_rot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  obb_pkg::box_pair_t box_i,
  input  logic [7:0]        eps_i,
  output logic              valid_o,
  input  logic              ready_i,
  output obb_pkg::rot_t     rot_o
);
  import obb_pkg::*;

  logic v1_q, v2_q, rdy1, rdy2;
  s32_t p_q[3][3][3];
  s17_t diff_q[3];
  s16_t a_q[3][3];
  u16_t ea_q[3], eb_q[3];
  rot_t rot_d, rot_q;
  s34_t dot[3][3];
  s20_t r[3][3];

  // stall chain
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign rot_o   = rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // stage 1: axis component products and center difference
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            p_q[i][j][k] <= box_i.a[i][k] * box_i.b[j][k];
          end
          a_q[i][j] <= box_i.a[i][j];
        end
        diff_q[i] <= s17_t'(box_i.cb[i]) - s17_t'(box_i.ca[i]);
        ea_q[i]   <= box_i.ea[i];
        eb_q[i]   <= box_i.eb[i];
      end
    end
  end

  // stage 2: round to q14, bias magnitude, offset products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dot[i][j] = s34_t'(p_q[i][j][0]) + s34_t'(p_q[i][j][1]) + s34_t'(p_q[i][j][2])
                    + s34_t'(1 <<< (Frac - 1));
        r[i][j] = dot[i][j][33:14];
        rot_d.r[i][j]  = r[i][j];
        rot_d.ar[i][j] = (r[i][j] < 0 ? -r[i][j] : r[i][j]) + s20_t'({1'b0, eps_i});
        rot_d.tp[i][j] = diff_q[j] * a_q[i][j];
      end
      rot_d.ea[i] = ea_q[i];
      rot_d.eb[i] = eb_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) rot_q <= rot_d;
  end

endmodule

/* hdl/obb_proj.sv */
module obb_proj (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  obb_pkg::rot_t rot_i,
  output logic          valid_o,
  input  logic          ready_i,
  output obb_pkg::proj_t proj_o
);
  import obb_pkg::*;

  logic v3_q, v4_q, rdy3, rdy4;
  s35_t t_q[3];
  s20_t r_q[3][3];
  s37_t eaar_q[3][3][3];
  s37_t ebar_q[3][3][3];
  u16_t ea_q[3], eb_q[3];
  proj_t proj_d, proj_q;
  s40_t rad_a[3];
  s35_t tmag[3];

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign ready_o = rdy3;
  assign valid_o = v4_q;
  assign proj_o  = proj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= valid_i;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 3: offset in frame of a, extent times rotation products
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= s35_t'(rot_i.tp[i][0]) + s35_t'(rot_i.tp[i][1]) + s35_t'(rot_i.tp[i][2]);
        for (int n = 0; n < 3; n++) begin
          r_q[i][n] <= rot_i.r[i][n];
          for (int j = 0; j < 3; j++) begin
            eaar_q[i][n][j] <= $signed({1'b0, rot_i.ea[i]}) * rot_i.ar[n][j];
            ebar_q[i][n][j] <= $signed({1'b0, rot_i.eb[i]}) * rot_i.ar[n][j];
          end
        end
        ea_q[i] <= rot_i.ea[i];
        eb_q[i] <= rot_i.eb[i];
      end
    end
  end

  // stage 4: radii sums, face-a tests, offset times rotation products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tmag[i]  = t_q[i] < 0 ? -t_q[i] : t_q[i];
      rad_a[i] = s40_t'({ea_q[i], 14'd0}) + s40_t'(ebar_q[0][i][0])
                 + s40_t'(ebar_q[1][i][1]) + s40_t'(ebar_q[2][i][2]);
      proj_d.sep_a[i] = s40_t'(tmag[i]) > rad_a[i];
      proj_d.rad_b[i] = s40_t'(eaar_q[0][0][i]) + s40_t'(eaar_q[1][1][i])
                        + s40_t'(eaar_q[2][2][i]) + s40_t'({eb_q[i], 14'd0});
      for (int j = 0; j < 3; j++) begin
        proj_d.rad_e[i][j] = s40_t'(eaar_q[Nx1[i]][Nx2[i]][j])
                             + s40_t'(eaar_q[Nx2[i]][Nx1[i]][j])
                             + s40_t'(ebar_q[Nx1[j]][i][Nx2[j]])
                             + s40_t'(ebar_q[Nx2[j]][i][Nx1[j]]);
        for (int n = 0; n < 3; n++) begin
          proj_d.tr[i][n][j] = t_q[i] * r_q[n][j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) proj_q <= proj_d;
  end

endmodule

/* hdl/obb_sep.sv */
module obb_sep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  obb_pkg::proj_t proj_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           overlap_o,
  output logic [3:0]     axis_o
);
  import obb_pkg::*;

  logic v5_q, v6_q, rdy5, rdy6;
  logic [NumAxes-1:0] flag_d, flag_q;
  logic [3:0] axis_d, axis_q;
  logic overlap_q;
  s58_t dist_b[3], mag_b[3];
  s58_t dist_e[3][3], mag_e[3][3];

  assign rdy6      = !v6_q || ready_i;
  assign rdy5      = !v5_q || rdy6;
  assign ready_o   = rdy5;
  assign valid_o   = v6_q;
  assign overlap_o = overlap_q;
  assign axis_o    = axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= valid_i;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // stage 5: face-b and edge distances against scaled radii
  always_comb begin
    flag_d[2:0] = proj_i.sep_a;
    for (int j = 0; j < 3; j++) begin
      dist_b[j] = s58_t'(proj_i.tr[0][0][j]) + s58_t'(proj_i.tr[1][1][j])
                  + s58_t'(proj_i.tr[2][2][j]);
      mag_b[j]  = dist_b[j] < 0 ? -dist_b[j] : dist_b[j];
      flag_d[3 + j] = mag_b[j] > (s58_t'(proj_i.rad_b[j]) <<< Frac);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dist_e[i][j] = s58_t'(proj_i.tr[Nx2[i]][Nx1[i]][j])
                       - s58_t'(proj_i.tr[Nx1[i]][Nx2[i]][j]);
        mag_e[i][j]  = dist_e[i][j] < 0 ? -dist_e[i][j] : dist_e[i][j];
        flag_d[6 + 3 * i + j] = mag_e[i][j] > (s58_t'(proj_i.rad_e[i][j]) <<< Frac);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) flag_q <= flag_d;
  end

  // stage 6: first separating axis wins
  always_comb begin
    axis_d = NoAxis;
    for (int k = NumAxes - 1; k >= 0; k--) begin
      if (flag_q[k]) axis_d = 4'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      axis_q    <= axis_d;
      overlap_q <= (axis_d == NoAxis);
    end
  end

endmodule

/* hdl/obb_chk.sv */
`include "obb_overlap_test_top_macros.svh"

module obb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       overlap_o,
  input logic [3:0] separating_axis_o
);
  import obb_pkg::*;

  // overlap flag agrees with the axis code
  `OBB_ASSERT_NOW(a_overlap_code, out_valid_o, overlap_o == (separating_axis_o == NoAxis), "overlap and axis disagree")

  // an empty output stage means the whole pipe can take an item
  `OBB_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

  // a stalled result holds
  `OBB_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(overlap_o) && $stable(separating_axis_o), "stalled result changed")

endmodule

bind obb_overlap_test_top obb_chk u_chk (.*);
